/* sv/root_directory_entry_parser_defines.svh */
// assertion macros for the root directory entry parser
// used by the top level; expects i_clk and i_rst_n in the including module
`ifndef ROOT_DIRECTORY_ENTRY_PARSER_DEFINES_SVH
`define ROOT_DIRECTORY_ENTRY_PARSER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RDEP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define RDEP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/rdep_pkg.sv */
// shared constants, key codes and entry type for the root directory entry parser
// no dependencies
package rdep_pkg;

    localparam int MAX_ENTRIES  = 16;
    localparam int POS_W        = $clog2(MAX_ENTRIES + 1);
    localparam int QUADLET_W    = 32;
    localparam int LEN_W        = 16;
    localparam int ID_W         = 6;
    localparam int VALUE_W      = 24;
    localparam int CODE_W       = 3;
    localparam int TYPE_W       = 2;
    localparam int OFFSET_W     = 25;
    localparam int OUT_FIELDS_W = CODE_W + VALUE_W + TYPE_W + OFFSET_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // key types
    localparam logic [TYPE_W-1:0] TYPE_IMMEDIATE = 2'd0;
    localparam logic [TYPE_W-1:0] TYPE_CSR       = 2'd1;
    localparam logic [TYPE_W-1:0] TYPE_LEAF      = 2'd2;
    localparam logic [TYPE_W-1:0] TYPE_DIRECTORY = 2'd3;

    // key ids
    localparam logic [ID_W-1:0] KEY_TEXT       = 6'h01;
    localparam logic [ID_W-1:0] KEY_VENDOR     = 6'h03;
    localparam logic [ID_W-1:0] KEY_MODEL      = 6'h17;
    localparam logic [ID_W-1:0] KEY_UNIT_SPEC  = 6'h12;
    localparam logic [ID_W-1:0] KEY_UNIT_SW    = 6'h13;
    localparam logic [ID_W-1:0] KEY_LOGICAL    = 6'h14;
    localparam logic [ID_W-1:0] KEY_NODE_CAPS  = 6'h0C;

    // dense key codes
    localparam logic [CODE_W-1:0] CODE_TEXT      = 3'd0;
    localparam logic [CODE_W-1:0] CODE_VENDOR    = 3'd1;
    localparam logic [CODE_W-1:0] CODE_MODEL     = 3'd2;
    localparam logic [CODE_W-1:0] CODE_UNIT_SPEC = 3'd3;
    localparam logic [CODE_W-1:0] CODE_UNIT_SW   = 3'd4;
    localparam logic [CODE_W-1:0] CODE_LOGICAL   = 3'd5;
    localparam logic [CODE_W-1:0] CODE_NODE_CAPS = 3'd6;

    typedef struct packed {
        logic                       recognized;
        logic [CODE_W-1:0]          code;
        logic [VALUE_W-1:0]         value;
        logic [TYPE_W-1:0]          ktype;
        logic signed [OFFSET_W-1:0] offset;
    } t_entry;

endpackage

/* sv/rdep_entry_decode.sv */
// entry quadlet decode: field split, key classification, leaf target offset
// depends on rdep_pkg
module rdep_entry_decode (
    input  logic [rdep_pkg::QUADLET_W-1:0] i_quadlet,
    input  logic [rdep_pkg::POS_W-1:0]     i_index,
    output rdep_pkg::t_entry               o_entry
);
    import rdep_pkg::*;

    always_comb begin
        logic [TYPE_W-1:0]          ktype;
        logic [ID_W-1:0]            id;
        logic [VALUE_W-1:0]         value;
        logic signed [OFFSET_W-1:0] sx;
        logic signed [OFFSET_W-1:0] idx_ext;
        logic                       hit;
        logic [CODE_W-1:0]          code;

        ktype   = i_quadlet[31:30];
        id      = i_quadlet[29:24];
        value   = i_quadlet[VALUE_W-1:0];
        sx      = {value[VALUE_W-1], value};
        idx_ext = {{(OFFSET_W-POS_W){1'b0}}, i_index};
        hit     = 1'b0;
        code    = CODE_TEXT;

        if (id == KEY_TEXT) begin
            // text descriptor only as a leaf
            hit  = (ktype == TYPE_LEAF);
            code = CODE_TEXT;
        end else if (ktype == TYPE_IMMEDIATE) begin
            hit = 1'b1;
            case (id)
                KEY_VENDOR:    code = CODE_VENDOR;
                KEY_MODEL:     code = CODE_MODEL;
                KEY_UNIT_SPEC: code = CODE_UNIT_SPEC;
                KEY_UNIT_SW:   code = CODE_UNIT_SW;
                KEY_LOGICAL:   code = CODE_LOGICAL;
                KEY_NODE_CAPS: code = CODE_NODE_CAPS;
                default:       hit  = 1'b0;
            endcase
        end

        o_entry.recognized = hit;
        o_entry.code       = code;
        o_entry.value      = value;
        o_entry.ktype      = ktype;
        // only a text leaf carries its absolute offset
        o_entry.offset     = (hit && code == CODE_TEXT) ? OFFSET_W'(sx + idx_ext) : '0;
    end

endmodule

/* sv/root_directory_entry_parser.sv */
// root directory entry parser top level: input stage, scan control, result register
// depends on rdep_pkg, rdep_entry_decode and root_directory_entry_parser_defines.svh
//
//  channel | dir | tdata                                     | tuser       | tlast
//  --------+-----+-------------------------------------------+-------------+---------------
//  s       | in  | quadlet[31:0]                             | -           | final_quadlet
//  m       | out | key_code, entry_value, key_kind, tgt_off  | entry_valid | directory_done
//
// one item per cycle sustained while the m side accepts; each quadlet is held in the input register
// and its result, if any, is loaded into the result register when the input stage advances
// the input register still takes one item, if it is empty, while a result waits on a stalled m side
// synchronous active-low reset returns the scan to expecting a header, no clearing pass
// items that produce no result (header with entries, ignored tail) never touch the m side
module root_directory_entry_parser (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // slave side
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [rdep_pkg::QUADLET_W-1:0]   i_s_tdata,   // quadlet[31:0]
    input  logic                             i_s_tlast,   // final_quadlet
    // master side
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // key_code[2:0], entry_value[26:3], key_kind[28:27], target_offset[53:29], zero pad
    output logic [rdep_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    output logic                             o_m_tuser,   // entry_valid
    output logic                             o_m_tlast    // directory_done
);
    import rdep_pkg::*;
    `include "root_directory_entry_parser_defines.svh"

    // scan phase codes; the unused code acts as expecting a header
    localparam logic [1:0] PHASE_HEADER = 2'd0;
    localparam logic [1:0] PHASE_SCAN   = 2'd1;
    localparam logic [1:0] PHASE_DRAIN  = 2'd2;

    // input register
    logic                 r_in_valid;
    logic [QUADLET_W-1:0] r_in_q;
    logic                 r_in_fin;

    // scan state
    logic [1:0]       r_phase, n_phase;
    logic [POS_W-1:0] r_pos,   n_pos;
    logic [POS_W-1:0] r_limit, n_limit;

    // result register
    logic   r_out_valid;
    t_entry r_out,      n_out;
    logic   r_out_done, n_out_done;
    logic   n_out_load;

    logic             w_advance;
    logic [POS_W-1:0] w_idx;
    t_entry           w_entry;

    // the input stage moves on when the result register is free or being drained
    assign w_advance  = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in_valid || w_advance;
    assign w_idx      = POS_W'(r_pos + 1'b1);

    rdep_entry_decode u_decode (
        .i_quadlet (r_in_q),
        .i_index   (w_idx),
        .o_entry   (w_entry)
    );

    always_comb begin
        logic [LEN_W-1:0] len;
        logic             done;

        len        = r_in_q[QUADLET_W-1 -: LEN_W];
        done       = r_in_fin || (w_idx >= r_limit);
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_limit    = r_limit;
        n_out_load = 1'b0;
        n_out      = '0;
        n_out_done = 1'b0;

        if (r_in_valid && w_advance) begin
            case (r_phase)
                PHASE_SCAN: begin
                    n_pos = w_idx;
                    if (done) begin
                        n_phase = r_in_fin ? PHASE_HEADER : PHASE_DRAIN;
                    end
                    if (w_entry.recognized) begin
                        n_out_load = 1'b1;
                        n_out      = w_entry;
                        n_out_done = done;
                    end else if (done) begin
                        // unrecognized entry that closes the scan: bare done mark
                        n_out_load = 1'b1;
                        n_out_done = 1'b1;
                    end
                end
                PHASE_DRAIN: begin
                    // tail past the scan limit is dropped up to the final item
                    if (r_in_fin) begin
                        n_phase = PHASE_HEADER;
                    end
                end
                default: begin
                    // header: clamp directory length to the entry limit
                    n_limit = (len < MAX_ENTRIES) ? POS_W'(len) : POS_W'(MAX_ENTRIES);
                    n_pos   = '0;
                    if (r_in_fin) begin
                        n_phase    = PHASE_HEADER;
                        n_out_load = 1'b1;
                        n_out_done = 1'b1;
                    end else if (len == '0) begin
                        n_phase    = PHASE_DRAIN;
                        n_out_load = 1'b1;
                        n_out_done = 1'b1;
                    end else begin
                        n_phase = PHASE_SCAN;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PHASE_HEADER;
            r_pos       <= '0;
            r_limit     <= '0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (w_advance) begin
                r_out_valid <= n_out_load;
            end
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_limit <= n_limit;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_q   <= i_s_tdata;
            r_in_fin <= i_s_tlast;
        end
        if (n_out_load) begin
            r_out      <= n_out;
            r_out_done <= n_out_done;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_DATA_W-OUT_FIELDS_W){1'b0}},
                         r_out.offset, r_out.ktype, r_out.value, r_out.code};
    assign o_m_tuser  = r_out.recognized;
    assign o_m_tlast  = r_out_done;

    // an unrecognized result exists only to carry the done mark
    `RDEP_ASSERT_NOW(a_bare_result_is_done, r_out_valid && !r_out.recognized, r_out_done, "bare result without done mark")
    // only a text leaf reports a target offset
    `RDEP_ASSERT_NOW(a_offset_only_text, r_out_valid && r_out.code != CODE_TEXT, r_out.offset == '0, "offset on non-text entry")
    // while scanning the position stays below a nonzero limit
    `RDEP_ASSERT_NOW(a_scan_bounds, r_phase == PHASE_SCAN, r_limit != '0 && r_pos < r_limit && r_limit <= POS_W'(MAX_ENTRIES), "scan position out of bounds")
    // a final item in the drain phase returns to header
    `RDEP_ASSERT_NEXT(a_drain_exit, r_in_valid && w_advance && r_in_fin && r_phase == PHASE_DRAIN, r_phase == PHASE_HEADER, "drain did not end on final item")

endmodule

/* test/directory_result_checker.sv */
// result checker for the root directory entry parser: watches both stream channels,
// predicts the result of every accepted quadlet and compares the results in order
// depends on rdep_pkg for widths, key ids, key types and key codes
module directory_result_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    input  logic                             i_s_tready,
    input  logic [rdep_pkg::QUADLET_W-1:0]   i_s_tdata,
    input  logic                             i_s_tlast,
    input  logic                             i_m_tvalid,
    input  logic                             i_m_tready,
    input  logic [rdep_pkg::OUT_DATA_W-1:0]  i_m_tdata,
    input  logic                             i_m_tuser,
    input  logic                             i_m_tlast,
    output int                               o_errors,
    output int                               o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import rdep_pkg::*;

    localparam int VALUE_LSB  = CODE_W;
    localparam int TYPE_LSB   = VALUE_LSB + VALUE_W;
    localparam int OFFSET_LSB = TYPE_LSB + TYPE_W;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_SCAN   = 2'd1,
        PH_DRAIN  = 2'd2
    } t_phase;

    typedef struct packed {
        t_entry entry;
        logic   done;
    } t_dir_result;

    t_dir_result         expected_results[$];
    t_phase              phase;
    logic [POS_W-1:0]    entry_pos;
    logic [POS_W-1:0]    entry_limit;
    int                  errors;
    int                  pending;

    assign o_errors      = errors;
    assign o_outstanding = pending;

    // update the scan state for one quadlet and queue its result, if any
    task automatic decode_quadlet(input logic [QUADLET_W-1:0] q, input logic fin);
        t_dir_result         r;
        logic [POS_W-1:0]    idx;
        logic [TYPE_W-1:0]   kt;
        logic [ID_W-1:0]     kid;
        logic [VALUE_W-1:0]  val;
        logic [CODE_W-1:0]   code;
        logic                hit;
        logic                done;
        logic [LEN_W-1:0]    len;
        r = '0;
        case (phase)
            PH_SCAN: begin
                idx  = entry_pos + 1'b1;
                kt   = q[31:30];
                kid  = q[29:24];
                val  = q[VALUE_W-1:0];
                hit  = 1'b0;
                code = '0;
                // text descriptor only as a leaf, the other known keys only as immediates
                case (kid)
                    KEY_TEXT:      begin hit = (kt == TYPE_LEAF);      code = CODE_TEXT;      end
                    KEY_VENDOR:    begin hit = (kt == TYPE_IMMEDIATE); code = CODE_VENDOR;    end
                    KEY_MODEL:     begin hit = (kt == TYPE_IMMEDIATE); code = CODE_MODEL;     end
                    KEY_UNIT_SPEC: begin hit = (kt == TYPE_IMMEDIATE); code = CODE_UNIT_SPEC; end
                    KEY_UNIT_SW:   begin hit = (kt == TYPE_IMMEDIATE); code = CODE_UNIT_SW;   end
                    KEY_LOGICAL:   begin hit = (kt == TYPE_IMMEDIATE); code = CODE_LOGICAL;   end
                    KEY_NODE_CAPS: begin hit = (kt == TYPE_IMMEDIATE); code = CODE_NODE_CAPS; end
                    default:       hit = 1'b0;
                endcase
                done      = fin || (idx >= entry_limit);
                entry_pos = idx;
                if (done) begin
                    phase = fin ? PH_HEADER : PH_DRAIN;
                end
                if (hit) begin
                    r.entry.recognized = 1'b1;
                    r.entry.code       = code;
                    r.entry.value      = val;
                    r.entry.ktype      = kt;
                    // text leaf: absolute offset is entry index plus signed 24-bit value
                    if (code == CODE_TEXT) begin
                        r.entry.offset = OFFSET_W'(idx) + {val[VALUE_W-1], val};
                    end
                    r.done = done;
                    expected_results = {expected_results, r};
                end else if (done) begin
                    r.done = 1'b1;
                    expected_results = {expected_results, r};
                end
            end
            PH_DRAIN: begin
                if (fin) begin
                    phase = PH_HEADER;
                end
            end
            default: begin
                len         = q[31:16];
                entry_limit = (len < MAX_ENTRIES) ? POS_W'(len) : POS_W'(MAX_ENTRIES);
                entry_pos   = '0;
                if (fin) begin
                    phase  = PH_HEADER;
                    r.done = 1'b1;
                    expected_results = {expected_results, r};
                end else if (entry_limit == 0) begin
                    phase  = PH_DRAIN;
                    r.done = 1'b1;
                    expected_results = {expected_results, r};
                end else begin
                    phase = PH_SCAN;
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_dir_result exp_r;
        t_dir_result got;
        logic        pad_ok;
        if (!i_rst_n) begin
            phase       = PH_HEADER;
            entry_pos   = '0;
            entry_limit = '0;
            expected_results.delete();
            errors      = 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                decode_quadlet(i_s_tdata, i_s_tlast);
            end
            if (i_m_tvalid && i_m_tready) begin
                got.entry.recognized = i_m_tuser;
                got.entry.code       = i_m_tdata[CODE_W-1:0];
                got.entry.value      = i_m_tdata[VALUE_LSB +: VALUE_W];
                got.entry.ktype      = i_m_tdata[TYPE_LSB +: TYPE_W];
                got.entry.offset     = i_m_tdata[OFFSET_LSB +: OFFSET_W];
                got.done             = i_m_tlast;
                pad_ok = (i_m_tdata >> OUT_FIELDS_W) == '0;
                if (expected_results.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display({"%0t: unexpected result valid=%0b code=%0d value=%06h",
                                  " type=%0d off=%0d done=%0b"},
                                 $time, got.entry.recognized, got.entry.code, got.entry.value,
                                 got.entry.ktype, got.entry.offset, got.done);
                    end
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got.entry.recognized !== exp_r.entry.recognized ||
                        got.entry.code !== exp_r.entry.code ||
                        got.entry.value !== exp_r.entry.value ||
                        got.entry.ktype !== exp_r.entry.ktype ||
                        got.entry.offset !== exp_r.entry.offset ||
                        got.done !== exp_r.done || pad_ok !== 1'b1) begin
                        errors++;
                        if (errors <= 10) begin
                            $display({"%0t: mismatch exp valid=%0b code=%0d value=%06h",
                                      " type=%0d off=%0d done=%0b"},
                                     $time, exp_r.entry.recognized, exp_r.entry.code,
                                     exp_r.entry.value, exp_r.entry.ktype, exp_r.entry.offset,
                                     exp_r.done);
                            $display({"%0t:          got valid=%0b code=%0d value=%06h",
                                      " type=%0d off=%0d done=%0b pad_ok=%0b"},
                                     $time, got.entry.recognized, got.entry.code,
                                     got.entry.value, got.entry.ktype, got.entry.offset,
                                     got.done, pad_ok);
                        end
                    end
                end
            end
        end
        pending = expected_results.size();
    end

endmodule

/* test/tb_root_directory_entry_parser.sv */
// testbench top for the root directory entry parser: drives quadlet directories,
// throttles the result side and gives the verdict from the result checker
// depends on rdep_pkg, root_directory_entry_parser and directory_result_checker
module tb_root_directory_entry_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import rdep_pkg::*;

    localparam int RAND_ITEMS  = 1400;
    localparam int QUIET_AFTER = 1250;   // last stretch of the run has no idling
    localparam int HOLD_CYCLES = 60;     // long receiver hold-off
    localparam int IDLE_LIMIT  = 2000;   // cycles without any handshake before giving up
    localparam int DRAIN_WAIT  = 10;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_s_tvalid = 1'b0;
    logic                    o_s_tready;
    logic [QUADLET_W-1:0]    i_s_tdata = '0;
    logic                    i_s_tlast = 1'b0;
    logic                    o_m_tvalid;
    logic                    i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   o_m_tdata;
    logic                    o_m_tuser;
    logic                    o_m_tlast;

    int                      errors;
    int                      outstanding;
    int                      idle_cycles = 0;
    int                      items_counted = 0;
    bit                      tx_idle_on = 1'b1;
    bit                      rx_idle_on = 1'b1;
    bit                      hold_req = 1'b0;

    // known key ids, the first one is the text descriptor
    logic [ID_W-1:0] known_ids [7] = '{KEY_TEXT, KEY_VENDOR, KEY_MODEL, KEY_UNIT_SPEC,
                                       KEY_UNIT_SW, KEY_LOGICAL, KEY_NODE_CAPS};

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    root_directory_entry_parser u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),    // quadlet[31:0]
        .i_s_tlast  (i_s_tlast),    // final_quadlet
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),    // key_code, entry_value, key_kind, target_offset, pad
        .o_m_tuser  (o_m_tuser),    // entry_valid
        .o_m_tlast  (o_m_tlast)     // directory_done
    );

    directory_result_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .i_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tlast     (i_s_tlast),
        .i_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .i_m_tdata     (o_m_tdata),
        .i_m_tuser     (o_m_tuser),
        .i_m_tlast     (o_m_tlast),
        .o_errors      (errors),
        .o_outstanding (outstanding)
    );

    // count cycles in which neither channel moves an item
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("CHECKS FAILED");
        $finish;
    end

    // result side: random stall bursts, one long hold-off on request
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
                i_m_tready <= 1'b1;
            end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge i_clk);
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // offer one quadlet, called at a falling edge, returns at the falling edge after acceptance
    task automatic send_quadlet(input logic [QUADLET_W-1:0] q, input logic fin);
        if (tx_idle_on && $urandom_range(0, 7) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= q;
        i_s_tlast  <= fin;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [23:0] random_value();
        case ($urandom_range(0, 5))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            2:       return 24'h800000;
            3:       return 24'h7FFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [QUADLET_W-1:0] random_entry();
        int k;
        k = $urandom_range(0, 6);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
                // well-formed known entry
                return {(k == 0) ? TYPE_LEAF : TYPE_IMMEDIATE, known_ids[k], random_value()};
            end
            6: begin
                // known id with a random type, often the wrong one
                return {2'($urandom), known_ids[k], random_value()};
            end
            default: return $urandom;
        endcase
    endfunction

    // header plus n_entries quadlets, the last one marked final
    task automatic send_directory(input logic [LEN_W-1:0] len, input int n_entries);
        send_quadlet({len, 16'($urandom)}, n_entries == 0);
        for (int i = 1; i <= n_entries; i++) begin
            send_quadlet(random_entry(), i == n_entries);
        end
        items_counted += 1 + n_entries;
    endtask

    initial begin
        logic [LEN_W-1:0] len;
        int               n_entries;
        bit               hold_done;

        hold_done = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // header marked final, all ones
        send_quadlet(32'hFFFF_FFFF, 1'b1);
        // zero length header, tail ignored through the final quadlet
        send_quadlet(32'h0000_0000, 1'b0);
        send_quadlet(32'hFFFF_FFFF, 1'b0);
        send_quadlet({KEY_VENDOR, 26'h0}, 1'b1);
        // scan limit reached before final: unrecognized entry ends the scan
        send_quadlet(32'h0003_ABCD, 1'b0);
        send_quadlet({TYPE_LEAF, KEY_TEXT, 24'h800000}, 1'b0);
        send_quadlet({TYPE_IMMEDIATE, KEY_VENDOR, 24'hFFFFFF}, 1'b0);
        send_quadlet({TYPE_CSR, KEY_VENDOR, 24'h123456}, 1'b0);
        send_quadlet(32'h0000_0000, 1'b0);
        send_quadlet(32'hFFFF_FFFF, 1'b1);
        // final quadlet within the scan, every known key but the vendor
        send_quadlet(32'h0009_0000, 1'b0);
        send_quadlet({TYPE_IMMEDIATE, KEY_MODEL, 24'h000000}, 1'b0);
        send_quadlet({TYPE_IMMEDIATE, KEY_UNIT_SPEC, 24'h00A02D}, 1'b0);
        send_quadlet({TYPE_IMMEDIATE, KEY_UNIT_SW, 24'h010001}, 1'b0);
        send_quadlet({TYPE_IMMEDIATE, KEY_LOGICAL, 24'h555555}, 1'b0);
        send_quadlet({TYPE_IMMEDIATE, KEY_NODE_CAPS, 24'hAAAAAA}, 1'b0);
        send_quadlet({TYPE_LEAF, KEY_TEXT, 24'h7FFFFF}, 1'b0);
        send_quadlet({TYPE_DIRECTORY, KEY_TEXT, 24'hFFFFFF}, 1'b0);
        send_quadlet({TYPE_IMMEDIATE, KEY_TEXT, 24'h000001}, 1'b1);
        // oversized length capped at the entry maximum, known final entry
        send_quadlet(32'hFFFF_0000, 1'b0);
        send_quadlet({TYPE_LEAF, KEY_TEXT, 24'hFFFFF0}, 1'b1);

        while (items_counted < RAND_ITEMS) begin
            if (items_counted >= QUIET_AFTER) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            if (!hold_done && items_counted >= RAND_ITEMS / 2) begin
                // block the result side and keep offering result-bearing entries
                hold_done  = 1'b1;
                tx_idle_on = 1'b0;
                hold_req   = 1'b1;
                @(negedge i_clk);
                send_quadlet(32'h0010_0000, 1'b0);
                for (int i = 1; i <= MAX_ENTRIES; i++) begin
                    send_quadlet({TYPE_IMMEDIATE, KEY_VENDOR, 24'($urandom)},
                                 i == MAX_ENTRIES);
                end
                items_counted += MAX_ENTRIES + 1;
                tx_idle_on = 1'b1;
            end
            case ($urandom_range(0, 9))
                0:       len = '0;
                1:       len = '1;
                2:       len = LEN_W'($urandom_range(MAX_ENTRIES + 1, 16'hFFFF));
                default: len = LEN_W'($urandom_range(1, MAX_ENTRIES));
            endcase
            case ($urandom_range(0, 5))
                0:       n_entries = 0;
                1:       n_entries = $urandom_range(0, 20);
                default: n_entries = (len < MAX_ENTRIES ? len : MAX_ENTRIES)
                                     + $urandom_range(0, 2) - 1;
            endcase
            if (n_entries < 0) begin
                n_entries = 0;
            end
            send_directory(len, n_entries);
        end

        i_s_tvalid <= 1'b0;
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (errors == 0 && outstanding == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* root_directory_entry_parser.f */
+incdir+sv
sv/rdep_pkg.sv
sv/rdep_entry_decode.sv
sv/root_directory_entry_parser.sv
test/directory_result_checker.sv
test/tb_root_directory_entry_parser.sv
